/* hw/rtl/mcbc_pkg.sv */
// ----------------------------------------------------------------------------
// mcbc_pkg: shared constants and types for the multiset containment checker
// Table geometry, request mode codes and the layout of one count table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbc_pkg;

    // table geometry
    localparam int VALUE_BITS  = 10;
    localparam int COUNT_BITS  = 11;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;

    // epoch tag kept with each count; a clear moves to the next epoch
    localparam int EPOCH_BITS  = 8;
    localparam int ENTRY_BITS  = EPOCH_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

    // request modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [COUNT_BITS-1:0] cnt;
    } t_entry;

endpackage

`default_nettype wire

/* hw/rtl/mcbc_ram.sv */
// ----------------------------------------------------------------------------
// mcbc_ram: simple dual-port synchronous RAM
// One write port and one read port, registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port: old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/multiset_containment_by_counts.sv */
// ----------------------------------------------------------------------------
// multiset_containment_by_counts: multiset subset check by a count table
// Load requests count values, check requests consume counts; a sticky miss
// flag tells whether every checked value was covered since the last clear.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------
//  in       | i_in_valid / o_in_stall    | i_mode[1:0], i_value[9:0]
//  out      | o_out_valid / i_out_stall  | o_contained, o_matched
//
//  One request per cycle unless stalled: a read of the count RAM, then modify
//  and write back in the modify stage, with the last write forwarded on a
//  same-entry collision. A result is registered as its request leaves that stage.
//  Clears bump an 8-bit epoch tag stored with each count; stale tags read zero.
//  After reset, and after every 256th clear, a pass rewrites the whole table
//  while the input is stalled, from the wrapping clear in the modify stage on.
//  Output stall backs up through the single modify stage into o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_containment_by_counts (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [mcbc_pkg::VALUE_BITS-1:0] i_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_contained,
    output logic                                o_matched
);

    import mcbc_pkg::*;

    logic                  in_acc;
    logic                  s1_adv;
    logic                  wrap_hold;

    // modify stage
    logic                  r_s1_vld;
    logic [1:0]            r_s1_mode;
    logic [VALUE_BITS-1:0] r_s1_idx;

    // forwarding of a write that collided with the read
    logic                  r_fwd_hit;
    t_entry                r_fwd_data;

    // status
    logic                  r_miss, n_miss;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic                  r_sweep, n_sweep;
    logic [VALUE_BITS-1:0] r_sweep_idx;

    // output register
    logic                  r_out_vld;
    logic                  r_contained;
    logic                  r_matched;

    // RAM ports
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_addr;
    t_entry                wr_entry;
    t_entry                rd_entry;
    t_entry                cur;
    logic [COUNT_BITS-1:0] cnt;
    logic                  hit;
    logic                  wrap;

    mcbc_ram #(
        .DATA_W (ENTRY_BITS),
        .ADDR_W (VALUE_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_value),
        .o_rd_data (rd_entry)
    );

    // handshake
    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign wrap_hold  = r_s1_vld && (r_s1_mode == MODE_CLEAR) && (r_epoch == EPOCH_LAST);
    assign o_in_stall = r_sweep || wrap_hold || (r_s1_vld && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;

    // read-modify-write of one count
    always_comb begin
        cur          = r_fwd_hit ? r_fwd_data : rd_entry;
        cnt          = (cur.tag == r_epoch) ? cur.cnt : '0;
        hit          = 1'b0;
        wrap         = 1'b0;
        n_miss       = r_miss;
        n_epoch      = r_epoch;
        wr_en        = 1'b0;
        wr_addr      = r_s1_idx;
        wr_entry.tag = r_epoch;
        wr_entry.cnt = cnt;
        n_sweep      = r_sweep;

        if (s1_adv) begin
            case (r_s1_mode)
                MODE_CLEAR: begin
                    n_miss  = 1'b0;
                    n_epoch = r_epoch + 1'b1;
                    wrap    = (r_epoch == EPOCH_LAST);
                end
                MODE_LOAD: begin
                    wr_en = 1'b1;
                    if (cnt != COUNT_MAX) begin
                        wr_entry.cnt = cnt + 1'b1;
                    end
                end
                MODE_CHECK: begin
                    hit = (cnt != '0);
                    if (!r_miss) begin
                        if (hit) begin
                            wr_en        = 1'b1;
                            wr_entry.cnt = cnt - 1'b1;
                        end else begin
                            n_miss = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // table rewrite pass owns the write port
        if (r_sweep) begin
            wr_en    = 1'b1;
            wr_addr  = r_sweep_idx;
            wr_entry = '0;
            if (r_sweep_idx == VALUE_BITS'(TABLE_DEPTH - 1)) begin
                n_sweep = 1'b0;
            end
        end else if (wrap) begin
            n_sweep = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_miss      <= 1'b0;
            r_epoch     <= '0;
            r_sweep     <= 1'b1;
            r_sweep_idx <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld  <= 1'b1;
                r_fwd_hit <= wr_en && (wr_addr == i_value);
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            r_miss  <= n_miss;
            r_epoch <= n_epoch;
            r_sweep <= n_sweep;
            if (r_sweep) begin
                r_sweep_idx <= r_sweep_idx + 1'b1;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode  <= i_mode;
            r_s1_idx   <= i_value;
            r_fwd_data <= wr_entry;
        end
        if (s1_adv) begin
            r_contained <= !n_miss;
            r_matched   <= hit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_contained = r_contained;
    assign o_matched   = r_matched;

`ifndef SYNTH
    // no request enters while the table is being rewritten
    a_sweep_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !in_acc)
        else $error("request accepted during table rewrite");

    // the rewrite pass and the modify stage never share the write port
    a_sweep_no_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !s1_adv)
        else $error("modify stage active during table rewrite");

    // a clear leaves the miss flag down
    a_clear_resets_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_mode == MODE_CLEAR) |=> (!r_miss && o_contained))
        else $error("miss flag set after clear");

    // the miss flag is sticky until a clear
    a_miss_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_miss && !(s1_adv && r_s1_mode == MODE_CLEAR)) |=> r_miss)
        else $error("miss flag dropped without clear");

    // a wrapping clear lets no request follow it into the modify stage
    a_wrap_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && wrap) |=> (!r_s1_vld && r_sweep))
        else $error("request in flight across epoch wrap");
`endif

endmodule

`default_nettype wire
